@@ design/ebs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ebs_pkg;

    localparam int CFG_W      = 16;
    localparam int LID_W      = 8;
    localparam int GAP_W      = 16;
    localparam int TICK_W     = 16;
    localparam int CHANCE_W   = 10;
    localparam int PAUSE_W    = 6;
    localparam int CMD_W      = 2;
    localparam int PHASE_W    = 2;
    localparam int ADDR_W     = 3;
    localparam int SQ_W       = 2 * TICK_W;
    localparam int NUM_W      = SQ_W + LID_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam int MOD_STEPS  = GAP_W;
    localparam int DIV_STEPS  = LID_W;
    localparam int STEP_CNT_W = $clog2(MOD_STEPS);

    localparam int PAUSE_TICKS_DEF = 50;

    localparam logic [TICK_W-1:0]   CLOSE_TICKS_RST  = 16'd60;
    localparam logic [TICK_W-1:0]   OPEN_TICKS_RST   = 16'd80;
    localparam logic [TICK_W-1:0]   HOLD_TICKS_RST   = 16'd30;
    localparam logic                AUTO_ENABLE_RST  = 1'b1;
    localparam logic [GAP_W-1:0]    MIN_GAP_RST      = 16'd2000;
    localparam logic [GAP_W-1:0]    MAX_GAP_RST      = 16'd5000;
    localparam logic [CHANCE_W-1:0] DOUBLE_PM_RST    = 10'd150;

    localparam logic [LID_W-1:0] LID_CLOSED = '1;
    localparam logic [LID_W-1:0] LID_OPEN   = '0;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_CLOSE_TICKS = 3'd0;
    localparam logic [ADDR_W-1:0] REG_OPEN_TICKS  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_HOLD_TICKS  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_AUTO_ENABLE = 3'd3;
    localparam logic [ADDR_W-1:0] REG_MIN_GAP     = 3'd4;
    localparam logic [ADDR_W-1:0] REG_MAX_GAP     = 3'd5;
    localparam logic [ADDR_W-1:0] REG_DOUBLE_PM   = 3'd6;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 2'd0,
        PH_CLOSING = 2'd1,
        PH_CLOSED  = 2'd2,
        PH_OPENING = 2'd3
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_BLINK  = 2'd1,
        CMD_WINK_L = 2'd2,
        CMD_WINK_R = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_MOD,
        S_EVAL,
        S_MULN,
        S_MULD,
        S_DIV,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic dispatch;
        logic mod_step;
        logic eval;
        logic mul_n;
        logic mul_d;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic curve_req;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/ebs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ebs_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  ebs_pkg::dp_status_t status,
    output ebs_pkg::dp_cmd_t    cmd
);

    ebs_pkg::ctrl_state_t state_reg, state_next;
    logic [ebs_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic mod_last, div_last;

    assign mod_last = (cnt_reg == ebs_pkg::STEP_CNT_W'(ebs_pkg::MOD_STEPS - 1));
    assign div_last = (cnt_reg == ebs_pkg::STEP_CNT_W'(ebs_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ebs_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            ebs_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = ebs_pkg::S_CMD;
            end
            ebs_pkg::S_CMD:
            begin
                state_next = status.is_tick ? ebs_pkg::S_MOD : ebs_pkg::S_DONE;
            end
            ebs_pkg::S_MOD:
            begin
                if (mod_last)
                    state_next = ebs_pkg::S_EVAL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ebs_pkg::S_EVAL:
            begin
                state_next = ebs_pkg::S_MULN;
            end
            ebs_pkg::S_MULN:
            begin
                state_next = status.curve_req ? ebs_pkg::S_MULD : ebs_pkg::S_DONE;
            end
            ebs_pkg::S_MULD:
            begin
                state_next = ebs_pkg::S_DIV;
            end
            ebs_pkg::S_DIV:
            begin
                if (div_last)
                    state_next = ebs_pkg::S_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ebs_pkg::S_DONE:
            begin
                if (status.out_free)
                    state_next = ebs_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        s_tready     = (state_reg == ebs_pkg::S_IDLE);
        cmd.latch    = (state_reg == ebs_pkg::S_IDLE) && s_tvalid;
        cmd.dispatch = (state_reg == ebs_pkg::S_CMD);
        cmd.mod_step = (state_reg == ebs_pkg::S_MOD);
        cmd.eval     = (state_reg == ebs_pkg::S_EVAL);
        cmd.mul_n    = (state_reg == ebs_pkg::S_MULN) && status.curve_req;
        cmd.mul_d    = (state_reg == ebs_pkg::S_MULD);
        cmd.div_step = (state_reg == ebs_pkg::S_DIV);
        cmd.finish   = (state_reg == ebs_pkg::S_DONE) && status.out_free;
    end

endmodule

`default_nettype wire

@@ design/ebs_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ebs_dpath #(
    parameter int unsigned PAUSE_TICKS = ebs_pkg::PAUSE_TICKS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  ebs_pkg::dp_cmd_t                   cmd,
    output ebs_pkg::dp_status_t                status,
    input  wire                                cfg_valid,
    input  wire  [ebs_pkg::ADDR_W-1:0]         cfg_addr,
    input  wire  [ebs_pkg::CFG_W-1:0]          cfg_data,
    input  wire  [ebs_pkg::CMD_W-1:0]          command,
    input  wire  [ebs_pkg::LID_W-1:0]          left_lid_in,
    input  wire  [ebs_pkg::LID_W-1:0]          right_lid_in,
    input  wire  [ebs_pkg::GAP_W-1:0]          rand_gap,
    input  wire  [ebs_pkg::CHANCE_W-1:0]       rand_chance,
    input  wire                                m_tready,
    output logic                               m_tvalid,
    output logic [ebs_pkg::LID_W-1:0]          left_lid_out,
    output logic [ebs_pkg::LID_W-1:0]          right_lid_out,
    output logic                               active,
    output logic [ebs_pkg::PHASE_W-1:0]        phase
);

    localparam int TW = ebs_pkg::TICK_W;
    localparam int LW = ebs_pkg::LID_W;
    localparam int GW = ebs_pkg::GAP_W;
    localparam int CW = ebs_pkg::CHANCE_W;
    localparam int PW = ebs_pkg::PAUSE_W;
    localparam int SW = ebs_pkg::SQ_W;
    localparam int NW = ebs_pkg::NUM_W;

    // Configuration.
    logic [TW-1:0] close_reg, close_next;
    logic [TW-1:0] open_reg, open_next;
    logic [TW-1:0] hold_reg, hold_next;
    logic          auto_reg, auto_next;
    logic [GW-1:0] min_reg, min_next;
    logic [GW-1:0] max_reg, max_next;
    logic [CW-1:0] dpm_reg, dpm_next;

    // Latched item.
    logic [ebs_pkg::CMD_W-1:0] command_reg, command_next;
    logic [LW-1:0] lin_reg, lin_next;
    logic [LW-1:0] rin_reg, rin_next;
    logic [GW-1:0] rgap_reg, rgap_next;
    logic [CW-1:0] rch_reg, rch_next;

    // Sequencer state.
    ebs_pkg::phase_t phase_reg, phase_next;
    logic          sel_l_reg, sel_l_next;
    logic          sel_r_reg, sel_r_next;
    logic [TW-1:0] elapsed_reg, elapsed_next;
    logic [PW-1:0] pause_reg, pause_next;
    logic          dbl_reg, dbl_next;
    logic [GW-1:0] cd_reg, cd_next;
    logic          sched_reg, sched_next;
    logic [LW-1:0] lid_l_reg, lid_l_next;
    logic [LW-1:0] lid_r_reg, lid_r_next;

    // Working registers.
    logic [GW-1:0] mod_rem_reg, mod_rem_next;
    logic [TW-1:0] n_reg, n_next;
    logic [TW-1:0] d_reg, d_next;
    logic [SW-1:0] n2_reg, n2_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] dsh_reg, dsh_next;
    logic [LW-1:0] lid_val_reg, lid_val_next;
    logic          lid_wr_reg, lid_wr_next;
    logic          curve_reg, curve_next;
    logic          active_reg, active_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] out_l_reg, out_l_next;
    logic [LW-1:0] out_r_reg, out_r_next;
    logic          out_act_reg, out_act_next;
    ebs_pkg::phase_t out_ph_reg, out_ph_next;

    logic [TW-1:0] mul_op;
    logic [SW-1:0] prod;

    assign mul_op = cmd.mul_d ? d_reg : n_reg;
    assign prod   = mul_op * mul_op;

    assign status.is_tick   = (command_reg == ebs_pkg::CMD_TICK);
    assign status.curve_req = curve_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign left_lid_out  = out_l_reg;
    assign right_lid_out = out_r_reg;
    assign active        = out_act_reg;
    assign phase         = out_ph_reg;

    always_comb
    begin
        logic [GW-1:0]   gap_span;
        logic [GW-1:0]   gap_value;
        logic [GW:0]     mod_trial;
        logic [GW-1:0]   cd1;
        logic            start;
        ebs_pkg::phase_t ph0;
        logic [TW-1:0]   e0;
        logic [TW-1:0]   e_use;
        logic [PW-1:0]   pause0;
        logic [PW-1:0]   pause_dec;
        logic            dbl0;
        logic            hold;
        logic            moved;
        logic [LW-1:0]   new_l;
        logic [LW-1:0]   new_r;

        close_next   = close_reg;
        open_next    = open_reg;
        hold_next    = hold_reg;
        auto_next    = auto_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        dpm_next     = dpm_reg;
        command_next = command_reg;
        lin_next     = lin_reg;
        rin_next     = rin_reg;
        rgap_next    = rgap_reg;
        rch_next     = rch_reg;
        phase_next   = phase_reg;
        sel_l_next   = sel_l_reg;
        sel_r_next   = sel_r_reg;
        elapsed_next = elapsed_reg;
        pause_next   = pause_reg;
        dbl_next     = dbl_reg;
        cd_next      = cd_reg;
        sched_next   = sched_reg;
        lid_l_next   = lid_l_reg;
        lid_r_next   = lid_r_reg;
        mod_rem_next = mod_rem_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        n2_next      = n2_reg;
        num_next     = num_reg;
        dsh_next     = dsh_reg;
        lid_val_next = lid_val_reg;
        lid_wr_next  = lid_wr_reg;
        curve_next   = curve_reg;
        active_next  = active_reg;
        out_valid_next = out_valid_reg;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        out_act_next = out_act_reg;
        out_ph_next  = out_ph_reg;

        gap_span  = max_reg - min_reg;
        gap_value = (max_reg > min_reg) ? min_reg + mod_rem_reg : min_reg;
        mod_trial = {mod_rem_reg, rgap_reg[GW-1]};

        cd1   = sched_reg ? gap_value : ((cd_reg != '0) ? cd_reg - 1'b1 : cd_reg);
        start = auto_reg && (phase_reg == ebs_pkg::PH_IDLE) && (cd1 == '0);
        ph0    = start ? ebs_pkg::PH_CLOSING : phase_reg;
        e0     = start ? '0 : elapsed_reg;
        pause0 = start ? '0 : pause_reg;
        dbl0   = start ? (rch_reg < dpm_reg) : dbl_reg;
        pause_dec = pause0 - 1'b1;
        e_use  = e0;
        hold   = 1'b0;
        moved  = 1'b0;

        new_l = (lid_wr_reg && sel_l_reg) ? lid_val_reg : lid_l_reg;
        new_r = (lid_wr_reg && sel_r_reg) ? lid_val_reg : lid_r_reg;

        if (cfg_valid)
        begin
            unique case (cfg_addr)
                ebs_pkg::REG_CLOSE_TICKS: close_next = cfg_data;
                ebs_pkg::REG_OPEN_TICKS:  open_next  = cfg_data;
                ebs_pkg::REG_HOLD_TICKS:  hold_next  = cfg_data;
                ebs_pkg::REG_AUTO_ENABLE:
                begin
                    auto_next = cfg_data[0];
                    if (cfg_data[0] && (phase_reg == ebs_pkg::PH_IDLE))
                        sched_next = 1'b1;
                end
                ebs_pkg::REG_MIN_GAP:     min_next = cfg_data;
                ebs_pkg::REG_MAX_GAP:     max_next = cfg_data;
                ebs_pkg::REG_DOUBLE_PM:   dpm_next = cfg_data[CW-1:0];
                default: ;
            endcase
        end

        if (cmd.latch)
        begin
            command_next = command;
            lin_next     = left_lid_in;
            rin_next     = right_lid_in;
            rgap_next    = rand_gap;
            rch_next     = rand_chance;
        end

        if (cmd.dispatch)
        begin
            mod_rem_next = '0;
            lid_wr_next  = 1'b0;
            curve_next   = 1'b0;
            if (command_reg != ebs_pkg::CMD_TICK)
            begin
                // A blink or wink request only starts from idle; time does not move.
                if (phase_reg == ebs_pkg::PH_IDLE)
                begin
                    sel_l_next   = (command_reg != ebs_pkg::CMD_WINK_R);
                    sel_r_next   = (command_reg != ebs_pkg::CMD_WINK_L);
                    phase_next   = ebs_pkg::PH_CLOSING;
                    elapsed_next = '0;
                    pause_next   = '0;
                    dbl_next     = (rch_reg < dpm_reg);
                end
                active_next = 1'b1;
            end
        end

        // One bit of the gap remainder per step.
        if (cmd.mod_step)
        begin
            if (mod_trial >= {1'b0, gap_span})
                mod_rem_next = GW'(mod_trial - {1'b0, gap_span});
            else
                mod_rem_next = mod_trial[GW-1:0];
            rgap_next = {rgap_reg[GW-2:0], 1'b0};
        end

        if (cmd.eval)
        begin
            sched_next   = 1'b0;
            cd_next      = cd1;
            phase_next   = ph0;
            sel_l_next   = start ? 1'b1 : sel_l_reg;
            sel_r_next   = start ? 1'b1 : sel_r_reg;
            elapsed_next = e0;
            pause_next   = pause0;
            dbl_next     = dbl0;
            active_next  = (ph0 != ebs_pkg::PH_IDLE);
            lid_wr_next  = 1'b0;
            curve_next   = 1'b0;
            if (ph0 != ebs_pkg::PH_IDLE)
            begin
                unique case (ph0)
                    ebs_pkg::PH_IDLE:
                    begin
                    end
                    ebs_pkg::PH_CLOSING:
                    begin
                        // The pause before a second blink holds the lids still.
                        if (pause0 != '0)
                        begin
                            pause_next = pause_dec;
                            if (pause_dec != '0)
                                hold = 1'b1;
                            else
                                e_use = '0;
                        end
                        if (!hold)
                        begin
                            lid_wr_next = 1'b1;
                            if (e_use >= close_reg)
                            begin
                                lid_val_next = ebs_pkg::LID_CLOSED;
                                phase_next   = ebs_pkg::PH_CLOSED;
                                moved        = 1'b1;
                            end
                            else
                            begin
                                n_next     = e_use;
                                d_next     = close_reg;
                                curve_next = 1'b1;
                            end
                        end
                    end
                    ebs_pkg::PH_CLOSED:
                    begin
                        lid_wr_next  = 1'b1;
                        lid_val_next = ebs_pkg::LID_CLOSED;
                        if (e0 >= hold_reg)
                        begin
                            phase_next = ebs_pkg::PH_OPENING;
                            moved      = 1'b1;
                        end
                    end
                    ebs_pkg::PH_OPENING:
                    begin
                        lid_wr_next = 1'b1;
                        if (e0 >= open_reg)
                        begin
                            lid_val_next = ebs_pkg::LID_OPEN;
                            if (dbl0)
                            begin
                                dbl_next   = 1'b0;
                                phase_next = ebs_pkg::PH_CLOSING;
                                pause_next = PW'(PAUSE_TICKS);
                                moved      = 1'b1;
                            end
                            else
                            begin
                                phase_next = ebs_pkg::PH_IDLE;
                                cd_next    = gap_value;
                            end
                        end
                        else
                        begin
                            n_next     = open_reg - e0;
                            d_next     = open_reg;
                            curve_next = 1'b1;
                        end
                    end
                endcase
                if (!hold)
                begin
                    if (moved)
                        elapsed_next = TW'(1);
                    else if (e_use != '1)
                        elapsed_next = e_use + 1'b1;
                    else
                        elapsed_next = e_use;
                end
            end
        end

        if (cmd.mul_n)
            n2_next = prod;

        if (cmd.mul_d)
        begin
            dsh_next     = {1'b0, prod, {(LW - 1){1'b0}}};
            num_next     = {n2_reg, {LW{1'b0}}} - {{LW{1'b0}}, n2_reg};
            lid_val_next = '0;
        end

        // Restoring division; the quotient is known to fit the lid width.
        if (cmd.div_step)
        begin
            if (num_reg >= dsh_reg)
            begin
                num_next     = num_reg - dsh_reg;
                lid_val_next = {lid_val_reg[LW-2:0], 1'b1};
            end
            else
            begin
                lid_val_next = {lid_val_reg[LW-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (cmd.finish)
        begin
            lid_l_next     = new_l;
            lid_r_next     = new_r;
            out_valid_next = 1'b1;
            out_l_next     = (active_reg && (new_l > lin_reg)) ? new_l : lin_reg;
            out_r_next     = (active_reg && (new_r > rin_reg)) ? new_r : rin_reg;
            out_act_next   = active_reg;
            out_ph_next    = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_reg     <= ebs_pkg::CLOSE_TICKS_RST;
            open_reg      <= ebs_pkg::OPEN_TICKS_RST;
            hold_reg      <= ebs_pkg::HOLD_TICKS_RST;
            auto_reg      <= ebs_pkg::AUTO_ENABLE_RST;
            min_reg       <= ebs_pkg::MIN_GAP_RST;
            max_reg       <= ebs_pkg::MAX_GAP_RST;
            dpm_reg       <= ebs_pkg::DOUBLE_PM_RST;
            phase_reg     <= ebs_pkg::PH_IDLE;
            sel_l_reg     <= 1'b0;
            sel_r_reg     <= 1'b0;
            elapsed_reg   <= '0;
            pause_reg     <= '0;
            dbl_reg       <= 1'b0;
            cd_reg        <= '0;
            sched_reg     <= 1'b1;
            lid_l_reg     <= '0;
            lid_r_reg     <= '0;
            lid_wr_reg    <= 1'b0;
            curve_reg     <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            close_reg     <= close_next;
            open_reg      <= open_next;
            hold_reg      <= hold_next;
            auto_reg      <= auto_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            dpm_reg       <= dpm_next;
            phase_reg     <= phase_next;
            sel_l_reg     <= sel_l_next;
            sel_r_reg     <= sel_r_next;
            elapsed_reg   <= elapsed_next;
            pause_reg     <= pause_next;
            dbl_reg       <= dbl_next;
            cd_reg        <= cd_next;
            sched_reg     <= sched_next;
            lid_l_reg     <= lid_l_next;
            lid_r_reg     <= lid_r_next;
            lid_wr_reg    <= lid_wr_next;
            curve_reg     <= curve_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        lin_reg     <= lin_next;
        rin_reg     <= rin_next;
        rgap_reg    <= rgap_next;
        rch_reg     <= rch_next;
        mod_rem_reg <= mod_rem_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        n2_reg      <= n2_next;
        num_reg     <= num_next;
        dsh_reg     <= dsh_next;
        lid_val_reg <= lid_val_next;
        out_l_reg   <= out_l_next;
        out_r_reg   <= out_r_next;
        out_act_reg <= out_act_next;
        out_ph_reg  <= out_ph_next;
    end

endmodule

`default_nettype wire

@@ design/eyelid_blink_sequencer.sv @@
// The controller latches an item, dispatches it, works a 16-step gap remainder, evaluates,
// squares numerator and denominator and runs an 8-step lid divider; a blink or wink request
// goes from dispatch to the result, a tick with no lid curve from evaluation to the result.
// One item at a time: the next item is taken only once the result is registered, which waits while the output is held.
// Reset (rst_n low, asynchronous) loads the register defaults, idles the lids and
// schedules a gap draw on the first tick; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module eyelid_blink_sequencer #(
    parameter int unsigned PAUSE_TICKS = ebs_pkg::PAUSE_TICKS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // [7:0] left_lid_in, [15:8] right_lid_in, [31:16] rand_gap, [41:32] rand_chance
    input  wire  [ebs_pkg::IN_DATA_W-1:0]       s_tdata,
    // [1:0] command
    input  wire  [ebs_pkg::CMD_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [7:0] left_lid_out, [15:8] right_lid_out, [16] active, [18:17] phase
    output logic [ebs_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ebs_pkg::ADDR_W-1:0]          cfg_addr,
    input  wire  [ebs_pkg::CFG_W-1:0]           cfg_data
);

    localparam int LW = ebs_pkg::LID_W;

    ebs_pkg::dp_cmd_t    cmd;
    ebs_pkg::dp_status_t status;

    logic [LW-1:0]               left_lid_out;
    logic [LW-1:0]               right_lid_out;
    logic                        active;
    logic [ebs_pkg::PHASE_W-1:0] phase;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(ebs_pkg::OUT_DATA_W - 2 * LW - 1 - ebs_pkg::PHASE_W){1'b0}},
                        phase, active, right_lid_out, left_lid_out};

    ebs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ebs_dpath #(
        .PAUSE_TICKS (PAUSE_TICKS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .command       (s_tuser),
        .left_lid_in   (s_tdata[7:0]),
        .right_lid_in  (s_tdata[15:8]),
        .rand_gap      (s_tdata[31:16]),
        .rand_chance   (s_tdata[41:32]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .left_lid_out  (left_lid_out),
        .right_lid_out (right_lid_out),
        .active        (active),
        .phase         (phase)
    );

    // A new result only appears from the finishing step of the controller.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.finish))
        else $error("result valid rose without a finishing step");

    // A result that reports no blink must report the idle phase.
    a_inactive_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !active) |-> (phase == ebs_pkg::PH_IDLE))
        else $error("inactive result with a non-idle phase");

    // The lid divider only runs when the evaluation asked for a curve value.
    a_div_needs_curve: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.mul_d) |-> status.curve_req)
        else $error("divider running without a curve request");

    // Items are worked one at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in progress");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ebs_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [PAUSE_W-1:0] PAUSE_RELOAD = PAUSE_W'(PAUSE_TICKS_DEF);

    typedef struct packed {
        command_t            cmd;
        logic [LID_W-1:0]    lid_l;
        logic [LID_W-1:0]    lid_r;
        logic [GAP_W-1:0]    gap;
        logic [CHANCE_W-1:0] chance;
    } eye_cmd_t;

    typedef struct packed {
        logic [LID_W-1:0] lid_l;
        logic [LID_W-1:0] lid_r;
        logic             active;
        phase_t           phase;
    } lids_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        eye_cmd_t          item;
        logic              typed;
        lids_t             want;
        logic [ADDR_W-1:0] addr;
        logic [CFG_W-1:0]  value;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ADDR_W-1:0]     cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // Register copies and sequencer state mirrored by the predictor.
    logic [TICK_W-1:0]   close_ticks_r = CLOSE_TICKS_RST;
    logic [TICK_W-1:0]   open_ticks_r  = OPEN_TICKS_RST;
    logic [TICK_W-1:0]   hold_ticks_r  = HOLD_TICKS_RST;
    logic                auto_en       = AUTO_ENABLE_RST;
    logic [GAP_W-1:0]    min_gap_r     = MIN_GAP_RST;
    logic [GAP_W-1:0]    max_gap_r     = MAX_GAP_RST;
    logic [CHANCE_W-1:0] double_pm     = DOUBLE_PM_RST;

    phase_t            blink_ph      = PH_IDLE;
    logic              sel_l         = 1'b0;
    logic              sel_r         = 1'b0;
    logic [TICK_W-1:0] elapsed       = '0;
    logic [PAUSE_W-1:0] pause_cnt    = '0;
    logic              dbl_pending   = 1'b0;
    logic [GAP_W-1:0]  gap_cnt       = '0;
    logic              sched_pending = 1'b1;
    logic [LID_W-1:0]  blink_l       = '0;
    logic [LID_W-1:0]  blink_r       = '0;

    lids_t lid_expect_q[$];
    int    lid_mismatches = 0;
    int    results_seen   = 0;
    int    cycle_count    = 0;
    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;

    eyelid_blink_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [LID_W-1:0] lid_curve(input int unsigned n, input int unsigned d);
        longint unsigned num;
        longint unsigned den;
        num = 64'(n);
        num = 255 * num * num;
        den = 64'(d);
        den = den * den;
        return LID_W'(num / den);
    endfunction

    function automatic logic [GAP_W-1:0] draw_gap(input logic [GAP_W-1:0] r);
        if (max_gap_r > min_gap_r)
            return GAP_W'(min_gap_r + r % (max_gap_r - min_gap_r));
        return min_gap_r;
    endfunction

    function automatic void launch_blink(input logic l, input logic r,
                                         input logic [CHANCE_W-1:0] chance);
        sel_l       = l;
        sel_r       = r;
        blink_ph    = PH_CLOSING;
        elapsed     = '0;
        pause_cnt   = '0;
        dbl_pending = chance < double_pm;
    endfunction

    function automatic void set_blink_lids(input logic [LID_W-1:0] v);
        if (sel_l)
            blink_l = v;
        if (sel_r)
            blink_r = v;
    endfunction

    function automatic void apply_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] v);
        case (addr)
            REG_CLOSE_TICKS: close_ticks_r = v;
            REG_OPEN_TICKS:  open_ticks_r = v;
            REG_HOLD_TICKS:  hold_ticks_r = v;
            REG_AUTO_ENABLE:
            begin
                auto_en = v[0];
                if (v[0] && blink_ph == PH_IDLE)
                    sched_pending = 1'b1;
            end
            REG_MIN_GAP:     min_gap_r = v;
            REG_MAX_GAP:     max_gap_r = v;
            REG_DOUBLE_PM:   double_pm = v[CHANCE_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the mirrored sequencer by one command and returns the lids it shows.
    function automatic lids_t step_eyelids(input eye_cmd_t it);
        lids_t       res;
        int unsigned e;
        logic        moved;
        logic        hold;
        if (it.cmd != CMD_TICK)
        begin
            if (blink_ph == PH_IDLE)
                launch_blink(it.cmd != CMD_WINK_R, it.cmd != CMD_WINK_L, it.chance);
        end
        else
        begin
            if (sched_pending)
            begin
                gap_cnt       = draw_gap(it.gap);
                sched_pending = 1'b0;
            end
            else if (gap_cnt != 0)
                gap_cnt = gap_cnt - 1'b1;
            if (auto_en && blink_ph == PH_IDLE && gap_cnt == 0)
                launch_blink(1'b1, 1'b1, it.chance);
        end
        res.active = blink_ph != PH_IDLE;

        if (it.cmd == CMD_TICK && res.active)
        begin
            e     = 32'(elapsed);
            moved = 1'b0;
            hold  = 1'b0;
            case (blink_ph)
                PH_CLOSING:
                begin
                    // The inter-blink pause holds the lids until its last tick.
                    if (pause_cnt != 0)
                    begin
                        pause_cnt = pause_cnt - 1'b1;
                        if (pause_cnt != 0)
                            hold = 1'b1;
                        else
                            e = 0;
                    end
                    if (!hold)
                    begin
                        if (e >= close_ticks_r)
                        begin
                            set_blink_lids(LID_CLOSED);
                            blink_ph = PH_CLOSED;
                            moved    = 1'b1;
                        end
                        else
                            set_blink_lids(lid_curve(e, close_ticks_r));
                    end
                end
                PH_CLOSED:
                begin
                    set_blink_lids(LID_CLOSED);
                    if (e >= hold_ticks_r)
                    begin
                        blink_ph = PH_OPENING;
                        moved    = 1'b1;
                    end
                end
                default:
                begin
                    if (e >= open_ticks_r)
                    begin
                        set_blink_lids(LID_OPEN);
                        if (dbl_pending)
                        begin
                            dbl_pending = 1'b0;
                            blink_ph    = PH_CLOSING;
                            pause_cnt   = PAUSE_RELOAD;
                            moved       = 1'b1;
                        end
                        else
                        begin
                            blink_ph = PH_IDLE;
                            gap_cnt  = draw_gap(it.gap);
                        end
                    end
                    else
                        set_blink_lids(lid_curve(open_ticks_r - e, open_ticks_r));
                end
            endcase
            if (!hold)
                elapsed = moved ? TICK_W'(1) : (e < 32'hFFFF ? TICK_W'(e + 1) : '1);
        end

        res.lid_l = (res.active && blink_l > it.lid_l) ? blink_l : it.lid_l;
        res.lid_r = (res.active && blink_r > it.lid_r) ? blink_r : it.lid_r;
        res.phase = blink_ph;
        return res;
    endfunction

    function automatic plan_row_t item_row(input command_t cmd, input logic [LID_W-1:0] l, r,
                                           input logic [GAP_W-1:0] g,
                                           input logic [CHANCE_W-1:0] c);
        plan_row_t row;
        row             = '0;
        row.kind        = ROW_ITEM;
        row.item.cmd    = cmd;
        row.item.lid_l  = l;
        row.item.lid_r  = r;
        row.item.gap    = g;
        row.item.chance = c;
        return row;
    endfunction

    function automatic plan_row_t checked_row(input command_t cmd, input logic [LID_W-1:0] l, r,
                                              input logic [GAP_W-1:0] g,
                                              input logic [CHANCE_W-1:0] c,
                                              input logic [LID_W-1:0] wl, wr,
                                              input logic wa, input phase_t wp);
        plan_row_t row;
        row             = item_row(cmd, l, r, g, c);
        row.typed       = 1'b1;
        row.want.lid_l  = wl;
        row.want.lid_r  = wr;
        row.want.active = wa;
        row.want.phase  = wp;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [ADDR_W-1:0] addr,
                                          input logic [CFG_W-1:0] v);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_REG;
        row.addr  = addr;
        row.value = v;
        return row;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_addr  = addr;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(addr, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(input eye_cmd_t it, input logic typed, input lids_t want);
        lids_t predicted;
        @(negedge clk);
        // Idle bursts land anywhere in the block's work on the previous item.
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 48)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.cmd;
        s_tdata  = {6'd0, it.chance, it.gap, it.lid_r, it.lid_l};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = step_eyelids(it);
        lid_expect_q.push_back(typed ? want : predicted);
    endtask

    task automatic hold_off();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (lid_expect_q.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        m_tready = $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge clk)
    begin : check_results
        lids_t want;
        lids_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.lid_l  = m_tdata[7:0];
            got.lid_r  = m_tdata[15:8];
            got.active = m_tdata[16];
            got.phase  = phase_t'(m_tdata[18:17]);
            results_seen++;
            if (lid_expect_q.size() == 0)
            begin
                lid_mismatches++;
                if (lid_mismatches <= 10)
                    $display("result %0d arrived with nothing expected: %h",
                             results_seen, m_tdata);
            end
            else
            begin
                want = lid_expect_q.pop_front();
                if (got.lid_l !== want.lid_l || got.lid_r !== want.lid_r ||
                    got.active !== want.active || got.phase !== want.phase)
                begin
                    lid_mismatches++;
                    if (lid_mismatches <= 10)
                    begin
                        $display("result %0d: expected L %0d R %0d act %0d ph %0d",
                                 results_seen, want.lid_l, want.lid_r, want.active,
                                 want.phase);
                        $display("    got L %0d R %0d act %0d ph %0d",
                                 got.lid_l, got.lid_r, got.active, got.phase);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t        plan[$];
        eye_cmd_t         it;
        int               cmd_pick;
        int               dbl_pick;
        logic [CFG_W-1:0] close_v;
        logic [CFG_W-1:0] open_v;
        logic [CFG_W-1:0] hold_v;
        logic [CFG_W-1:0] min_v;
        logic [CFG_W-1:0] max_v;
        logic [CFG_W-1:0] dbl_v;
        logic             auto_v;

        // Reset defaults, a left wink with commands ignored while it runs.
        plan.push_back(checked_row(CMD_TICK, 8'd0, 8'd255, 16'h0000, 10'd0,
                                   8'd0, 8'd255, 1'b0, PH_IDLE));
        plan.push_back(checked_row(CMD_TICK, 8'd255, 8'd0, 16'hFFFF, 10'd999,
                                   8'd255, 8'd0, 1'b0, PH_IDLE));
        plan.push_back(checked_row(CMD_WINK_L, 8'd17, 8'd200, 16'd1234, 10'd999,
                                   8'd17, 8'd200, 1'b1, PH_CLOSING));
        plan.push_back(checked_row(CMD_BLINK, 8'd0, 8'd0, 16'd0, 10'd0,
                                   8'd0, 8'd0, 1'b1, PH_CLOSING));
        plan.push_back(checked_row(CMD_WINK_R, 8'd128, 8'd128, 16'hAAAA, 10'd512,
                                   8'd128, 8'd128, 1'b1, PH_CLOSING));
        plan.push_back(checked_row(CMD_TICK, 8'd0, 8'd0, 16'h5555, 10'd0,
                                   8'd0, 8'd0, 1'b1, PH_CLOSING));
        plan.push_back(item_row(CMD_TICK, 8'd90, 8'd255, 16'd7, 10'd3));
        // Shortest phases, zero hold, certain double blink, fixed gap.
        plan.push_back(reg_row(REG_CLOSE_TICKS, 16'd1));
        plan.push_back(reg_row(REG_HOLD_TICKS, 16'd0));
        plan.push_back(reg_row(REG_OPEN_TICKS, 16'd1));
        plan.push_back(reg_row(REG_DOUBLE_PM, 16'd1000));
        plan.push_back(reg_row(REG_MIN_GAP, 16'd7));
        plan.push_back(reg_row(REG_MAX_GAP, 16'd7));
        plan.push_back(checked_row(CMD_TICK, 8'd0, 8'd0, 16'd0, 10'd0,
                                   8'd255, 8'd0, 1'b1, PH_CLOSED));
        plan.push_back(item_row(CMD_TICK, 8'd33, 8'd44, 16'd9, 10'd100));
        plan.push_back(item_row(CMD_TICK, 8'd255, 8'd1, 16'h8001, 10'd1));
        plan.push_back(checked_row(CMD_BLINK, 8'd255, 8'd255, 16'hFFFF, 10'd999,
                                   8'd255, 8'd255, 1'b1, PH_CLOSING));
        plan.push_back(item_row(CMD_TICK, 8'd5, 8'd6, 16'h1234, 10'd0));
        plan.push_back(item_row(CMD_TICK, 8'd0, 8'd0, 16'h4321, 10'd700));
        plan.push_back(item_row(CMD_TICK, 8'd200, 8'd10, 16'h0F0F, 10'd24));
        plan.push_back(item_row(CMD_TICK, 8'd10, 8'd200, 16'hF0F0, 10'd999));
        // The double blink now waits in its pause with both lids open.
        plan.push_back(checked_row(CMD_TICK, 8'd255, 8'd255, 16'd0, 10'd0,
                                   8'd255, 8'd255, 1'b1, PH_CLOSING));
        plan.push_back(checked_row(CMD_WINK_R, 8'd0, 8'd0, 16'd0, 10'd0,
                                   8'd0, 8'd0, 1'b1, PH_CLOSING));
        plan.push_back(reg_row(REG_AUTO_ENABLE, 16'd0));
        plan.push_back(item_row(CMD_TICK, 8'd64, 8'd192, 16'd3, 10'd7));
        plan.push_back(item_row(CMD_WINK_L, 8'd1, 8'd254, 16'd3, 10'd7));
        plan.push_back(reg_row(REG_AUTO_ENABLE, 16'd1));
        plan.push_back(item_row(CMD_TICK, 8'd127, 8'd128, 16'h7FFF, 10'd511));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 68;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                hold_off();
                write_reg(plan[i].addr, plan[i].value);
            end
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 68;
            end
            else if (p < 6)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 2)
            begin
                close_v = 16'd1;
                open_v  = 16'd1;
                hold_v  = 16'd0;
                min_v   = 16'd0;
                max_v   = 16'd0;
                dbl_v   = 16'd0;
                auto_v  = 1'b1;
            end
            else if (p == 5)
            begin
                close_v = 16'hFFFF;
                open_v  = 16'hFFFF;
                hold_v  = 16'hFFFF;
                min_v   = 16'hFFFF;
                max_v   = 16'hFFFF;
                dbl_v   = 16'd1000;
                auto_v  = 1'b1;
            end
            else
            begin
                close_v  = CFG_W'(($urandom_range(7) == 0) ? $urandom_range(1, 40)
                                                           : $urandom_range(1, 6));
                open_v   = CFG_W'(($urandom_range(7) == 0) ? $urandom_range(1, 40)
                                                           : $urandom_range(1, 6));
                hold_v   = CFG_W'($urandom_range(0, 5));
                min_v    = CFG_W'($urandom_range(0, 40));
                max_v    = CFG_W'($urandom_range(0, 80));
                dbl_pick = $urandom_range(3);
                dbl_v    = (dbl_pick == 0) ? 16'd0 :
                           (dbl_pick == 1) ? 16'd1000 : CFG_W'($urandom_range(0, 1000));
                if (p == 0)
                    dbl_v = 16'd1000;
                auto_v   = (p == 7) ? 1'b0 : ($urandom_range(3) != 0);
            end

            hold_off();
            write_reg(REG_CLOSE_TICKS, close_v);
            write_reg(REG_OPEN_TICKS, open_v);
            write_reg(REG_HOLD_TICKS, hold_v);
            write_reg(REG_MIN_GAP, min_v);
            write_reg(REG_MAX_GAP, max_v);
            write_reg(REG_DOUBLE_PM, dbl_v);
            write_reg(REG_AUTO_ENABLE, {15'd0, auto_v});

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Mostly ticks, with manual blinks and winks mixed in.
                cmd_pick  = $urandom_range(0, 19);
                it.cmd    = (cmd_pick < 17) ? CMD_TICK : command_t'(cmd_pick - 16);
                it.lid_l  = ($urandom_range(3) == 0) ? {LID_W{$urandom_range(1) == 1}}
                                                     : LID_W'($urandom);
                it.lid_r  = ($urandom_range(3) == 0) ? {LID_W{$urandom_range(1) == 1}}
                                                     : LID_W'($urandom);
                it.gap    = GAP_W'($urandom);
                it.chance = CHANCE_W'($urandom_range(0, 999));
                if ($urandom_range(99) == 0)
                    hold_off();
                send_item(it, 1'b0, '0);
            end
        end

        hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (lid_mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
